>>> hw/rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// No dependencies; imported by the cell and the top level.
package spq_pkg;

    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

endpackage

>>> hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds a priority and a tag, shifts with its neighbors.
// Depends on spq_pkg (t_cell_cmd).
module spq_cell #(
    parameter int PRIO_BITS = 4,
    parameter int TAG_BITS  = 16
) (
    input  logic                   i_clk,
    input  spq_pkg::t_cell_cmd     i_cmd,
    input  logic                   i_occupied,
    input  logic [PRIO_BITS-1:0]   i_new_prio,
    input  logic [TAG_BITS-1:0]    i_new_tag,
    input  logic                   i_left_ge,
    input  logic [PRIO_BITS-1:0]   i_left_prio,
    input  logic [TAG_BITS-1:0]    i_left_tag,
    input  logic [PRIO_BITS-1:0]   i_right_prio,
    input  logic [TAG_BITS-1:0]    i_right_tag,
    output logic                   o_ge,
    output logic [PRIO_BITS-1:0]   o_prio,
    output logic [TAG_BITS-1:0]    o_tag
);
    import spq_pkg::*;

    logic [PRIO_BITS-1:0] r_prio, n_prio;
    logic [TAG_BITS-1:0]  r_tag, n_tag;

    // held entry stays ahead of the new one on equal priority
    assign o_ge   = i_occupied && (r_prio >= i_new_prio);
    assign o_prio = r_prio;
    assign o_tag  = r_tag;

    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_cmd.push && !o_ge) begin
            if (i_left_ge) begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end else begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end
        end else if (i_cmd.pop) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

endmodule

>>> hw/rtl/spq_out_buf.sv
// Result register with a skid stage, so a result can be produced while the last one waits.
// No package dependencies.
module spq_out_buf #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_stall
);
    logic         r_out_valid, r_skid_valid;
    logic [W-1:0] r_out_data, r_skid_data;
    logic         w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_full     = r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

>>> hw/rtl/stable_priority_queue_core.sv
// Stable priority queue top level: a chain of spq_cell slots plus count and result buffer.
// Depends on spq_pkg, spq_cell, spq_out_buf.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------------
//  request | in        | i_in_valid / o_in_stall | i_req_type, i_priority_req, i_tag
//  result  | out       | o_out_valid/i_out_stall | o_pop_valid, o_pop_priority, o_pop_tag,
//          |           |                        | o_status, o_entry_count, o_is_empty
//
// One transaction per cycle while o_in_stall is low: every cell compares against the new
// priority and shifts in the same cycle; the result is registered in the output buffer.
// Reset clears the entry count and the result buffer; slot contents are left as they are.
// o_in_stall rises when the skid stage holds a result behind a stalled output register.
module stable_priority_queue_core #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 4,
    parameter int TAG_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [PRIO_BITS-1:0]         i_priority_req,
    input  logic [TAG_BITS-1:0]          i_tag,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_pop_valid,
    output logic [PRIO_BITS-1:0]         o_pop_priority,
    output logic [TAG_BITS-1:0]          o_pop_tag,
    output logic [spq_pkg::STATUS_W-1:0] o_status,
    output logic [spq_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                         o_is_empty
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RES_W = 1 + PRIO_BITS + TAG_BITS + STATUS_W + COUNT_W + 1;

    logic [CNT_W-1:0]     r_count, n_count;
    logic                 w_accept, w_full, w_empty;
    t_cell_cmd            w_cmd;
    logic [STATUS_W-1:0]  w_status;
    logic [PRIO_BITS-1:0] w_res_prio;
    logic [TAG_BITS-1:0]  w_res_tag;
    logic [RES_W-1:0]     w_res, w_out_data;

    logic                 w_ge   [DEPTH];
    logic [PRIO_BITS-1:0] w_prio [DEPTH];
    logic [TAG_BITS-1:0]  w_tag  [DEPTH];

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_cmd.push = w_accept && (i_req_type == REQ_INSERT) && !w_full;
        w_cmd.pop  = w_accept && (i_req_type == REQ_POP) && !w_empty;
        n_count    = r_count;
        w_status   = STATUS_OK;
        if (w_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.pop) begin
            n_count = r_count - 1'b1;
        end
        if (i_req_type == REQ_POP && w_empty) begin
            w_status = STATUS_EMPTY;
        end else if (i_req_type == REQ_INSERT && w_full) begin
            w_status = STATUS_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                 w_left_ge;
            logic [PRIO_BITS-1:0] w_left_prio, w_right_prio;
            logic [TAG_BITS-1:0]  w_left_tag, w_right_tag;

            if (gi == 0) begin : g_head
                assign w_left_ge   = 1'b1;
                assign w_left_prio = i_priority_req;
                assign w_left_tag  = i_tag;
            end else begin : g_body
                assign w_left_ge   = w_ge[gi-1];
                assign w_left_prio = w_prio[gi-1];
                assign w_left_tag  = w_tag[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_right_prio = w_prio[gi];
                assign w_right_tag  = w_tag[gi];
            end else begin : g_mid
                assign w_right_prio = w_prio[gi+1];
                assign w_right_tag  = w_tag[gi+1];
            end

            spq_cell #(
                .PRIO_BITS (PRIO_BITS),
                .TAG_BITS  (TAG_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_occupied   (CNT_W'(gi) < r_count),
                .i_new_prio   (i_priority_req),
                .i_new_tag    (i_tag),
                .i_left_ge    (w_left_ge),
                .i_left_prio  (w_left_prio),
                .i_left_tag   (w_left_tag),
                .i_right_prio (w_right_prio),
                .i_right_tag  (w_right_tag),
                .o_ge         (w_ge[gi]),
                .o_prio       (w_prio[gi]),
                .o_tag        (w_tag[gi])
            );
        end
    endgenerate

    assign w_res_prio = w_cmd.pop ? w_prio[0] : '0;
    assign w_res_tag  = w_cmd.pop ? w_tag[0] : '0;
    assign w_res = {w_cmd.pop, w_res_prio, w_res_tag, w_status,
                    COUNT_W'(n_count), (n_count == '0)};

    spq_out_buf #(
        .W (RES_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_data  (w_res),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (w_out_data),
        .i_stall (i_out_stall)
    );

    assign {o_pop_valid, o_pop_priority, o_pop_tag, o_status,
            o_entry_count, o_is_empty} = w_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not raise count");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not lower count");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pop_valid) |-> (o_status == STATUS_OK && !o_is_empty ||
                                          o_status == STATUS_OK && o_is_empty))
        else $error("popped entry with error status");

    generate
        for (gi = 0; gi < DEPTH - 1; gi++) begin : g_sorted
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (CNT_W'(gi + 1) < r_count) |-> (w_prio[gi] >= w_prio[gi+1]))
                else $error("chain out of priority order");
        end
    endgenerate
`endif

endmodule
